FILE: rtl/stepper_button_move_sequencer_assert.svh
// Assertion macros for the stepper button move sequencer
`ifndef STEPPER_BUTTON_MOVE_SEQUENCER_ASSERT_SVH
`define STEPPER_BUTTON_MOVE_SEQUENCER_ASSERT_SVH

// property holds at every edge outside reset
`define SBMS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define SBMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/sbms_pkg.sv
// Package: types and constants shared by the move sequencer modules
package sbms_pkg;

	localparam int unsigned HALF_W   = 16;
	localparam int unsigned STEP_W   = 16;
	localparam int unsigned TIMER_W  = 20;
	localparam int unsigned ADDR_W   = 4;
	localparam int unsigned DATA_W   = 32;

	localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
	localparam logic [1:0] REG_PULSE_COUNT = 2'd1;
	localparam logic [1:0] REG_DIR_SETTLE  = 2'd2;
	localparam logic [1:0] REG_POST_WAIT   = 2'd3;

	localparam logic [HALF_W-1:0]  HALF_PERIOD_RST = HALF_W'(290);
	localparam logic [STEP_W-1:0]  PULSE_COUNT_RST = STEP_W'(30000);
	localparam logic [TIMER_W-1:0] DIR_SETTLE_RST  = TIMER_W'(50000);
	localparam logic [TIMER_W-1:0] POST_WAIT_RST   = TIMER_W'(50000);

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_SETTLE = 3'd1,
		PH_HIGH   = 3'd2,
		PH_LOW    = 3'd3,
		PH_POST   = 3'd4
	} phase_t;

	typedef struct packed {
		logic [HALF_W-1:0]  half_period_ticks;
		logic [STEP_W-1:0]  pulse_count;
		logic [TIMER_W-1:0] dir_settle_ticks;
		logic [TIMER_W-1:0] post_wait_ticks;
	} cfg_t;

	typedef struct packed {
		logic busy_res;
		logic enable_n;
		logic dir_level;
		logic step_pulse;
	} result_t;

endpackage

FILE: rtl/stepper_button_move_sequencer.sv
// Top level: stream ports, input stage, sequencer core and result register
//
// Usage:
//   s_axis carries one item per timer tick: tdata[0] up button, tdata[1] down button
//   (both active low). m_axis returns one item per input item: tdata[0] step_pulse,
//   tdata[1] dir_level, tdata[2] enable_n, tdata[3] busy_res, the line levels after
//   that tick. Timing registers are written over APB while the block is idle:
//   0x0 half period, 0x4 step count, 0x8 direction settle, 0xC post wait.
// Path: the input item is registered in the input stage, then the sequencer update
//   loads the result register, which drives m_axis; the receiver takes it when
//   m_axis_tready is high. The phase machine and timers update once per item.
// Throughput: one item per cycle while m_axis_tready is high.
// Reset: phase idle, latches clear, timers zero, registers at their defaults;
//   no result is pending.
// Stall: with m_axis_tready low the result register holds and one more item waits
//   in the input stage; s_axis_tready then drops until the output drains.
module stepper_button_move_sequencer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,  // btn_up_n, btn_dn_n, zero pad
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [7:0]                  m_axis_tdata,  // step_pulse, dir_level, enable_n,
	                                                   // busy_res, zero pad
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sbms_pkg::ADDR_W-1:0] paddr,
	input  logic [sbms_pkg::DATA_W-1:0] pwdata,
	output logic [sbms_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import sbms_pkg::*;

	cfg_t       cfg;
	result_t    result;
	logic       valid_s1;
	logic [1:0] btn_s1;
	logic       adv;
	logic       out_valid_q;
	result_t    out_q;

	assign adv           = valid_s1 & (!out_valid_q | m_axis_tready);
	assign s_axis_tready = !valid_s1 | adv;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_q.busy_res, out_q.enable_n,
		out_q.dir_level, out_q.step_pulse};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			btn_s1 <= s_axis_tdata[1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= result;
		end
	end

	sbms_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sbms_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (adv),
		.btn_up_n   (btn_s1[0]),
		.btn_dn_n   (btn_s1[1]),
		.cfg        (cfg),
		.result     (result)
	);

endmodule

FILE: rtl/sbms_regs.sv
// Configuration register file behind the APB port
module sbms_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sbms_pkg::ADDR_W-1:0] paddr,
	input  logic [sbms_pkg::DATA_W-1:0] pwdata,
	output logic [sbms_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output sbms_pkg::cfg_t              cfg
);
	import sbms_pkg::*;

	logic       wr_en;
	logic [1:0] reg_idx;
	cfg_t       cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks <= HALF_PERIOD_RST;
			cfg_q.pulse_count       <= PULSE_COUNT_RST;
			cfg_q.dir_settle_ticks  <= DIR_SETTLE_RST;
			cfg_q.post_wait_ticks   <= POST_WAIT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_HALF_PERIOD: cfg_q.half_period_ticks <= pwdata[HALF_W-1:0];
				REG_PULSE_COUNT: cfg_q.pulse_count       <= pwdata[STEP_W-1:0];
				REG_DIR_SETTLE:  cfg_q.dir_settle_ticks  <= pwdata[TIMER_W-1:0];
				REG_POST_WAIT:   cfg_q.post_wait_ticks   <= pwdata[TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_HALF_PERIOD: prdata = DATA_W'(cfg_q.half_period_ticks);
			REG_PULSE_COUNT: prdata = DATA_W'(cfg_q.pulse_count);
			REG_DIR_SETTLE:  prdata = DATA_W'(cfg_q.dir_settle_ticks);
			REG_POST_WAIT:   prdata = DATA_W'(cfg_q.post_wait_ticks);
			default:         prdata = '0;
		endcase
	end

endmodule

FILE: rtl/sbms_core.sv
// Move sequencer state: phase machine, tick timer, step counter and latches
module sbms_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              btn_up_n,
	input  logic              btn_dn_n,
	input  sbms_pkg::cfg_t    cfg,
	output sbms_pkg::result_t result
);
	import sbms_pkg::*;

	phase_t              phase_q, phase_n;
	logic [TIMER_W-1:0]  timer_q, timer_n;
	logic [STEP_W-1:0]   steps_q, steps_n;
	logic                dir_q, dir_n;
	logic                up_l_q, up_l_n;
	logic                down_l_q, down_l_n;
	logic                pulse_q, pulse_n;
	logic [TIMER_W-1:0]  half_m1;

	assign half_m1 = (cfg.half_period_ticks == '0) ? '0 :
		TIMER_W'(cfg.half_period_ticks - HALF_W'(1));

	always_comb begin
		logic do_pulsing;
		logic do_high;
		logic do_post;
		do_pulsing = 1'b0;
		do_high    = 1'b0;
		do_post    = 1'b0;
		phase_n    = phase_q;
		timer_n    = timer_q;
		steps_n    = steps_q;
		dir_n      = dir_q;
		up_l_n     = up_l_q;
		down_l_n   = down_l_q;
		pulse_n    = pulse_q;
		unique case (phase_q)
			PH_SETTLE: begin
				if (timer_q != '0) timer_n = timer_q - TIMER_W'(1);
				else do_pulsing = 1'b1;
			end
			PH_HIGH: begin
				if (timer_q != '0) begin
					timer_n = timer_q - TIMER_W'(1);
				end else begin
					phase_n = PH_LOW;
					pulse_n = 1'b0;
					timer_n = half_m1;
				end
			end
			PH_LOW: begin
				if (timer_q != '0) begin
					timer_n = timer_q - TIMER_W'(1);
				end else begin
					steps_n = steps_q - STEP_W'(1);
					if (steps_n == '0) do_post = 1'b1;
					else do_high = 1'b1;
				end
			end
			PH_POST: begin
				if (timer_q != '0) begin
					timer_n = timer_q - TIMER_W'(1);
				end else begin
					phase_n = PH_IDLE;
					if (dir_q) up_l_n = 1'b1;
					else down_l_n = 1'b1;
				end
			end
			default: begin
				phase_n = PH_IDLE;
				if ((!btn_up_n && !up_l_q) || (!btn_dn_n && !down_l_q)) begin
					dir_n = !btn_up_n && !up_l_q;
					if (dir_n) down_l_n = 1'b0;
					else up_l_n = 1'b0;
					pulse_n = 1'b0;
					if (cfg.dir_settle_ticks == '0) begin
						do_pulsing = 1'b1;
					end else begin
						phase_n = PH_SETTLE;
						timer_n = cfg.dir_settle_ticks - TIMER_W'(1);
					end
				end
			end
		endcase
		if (do_pulsing) begin
			steps_n = cfg.pulse_count;
			if (cfg.pulse_count == '0) do_post = 1'b1;
			else do_high = 1'b1;
		end
		if (do_high) begin
			phase_n = PH_HIGH;
			pulse_n = 1'b1;
			timer_n = half_m1;
		end
		if (do_post) begin
			pulse_n = 1'b0;
			if (cfg.post_wait_ticks == '0) begin
				phase_n = PH_IDLE;
				timer_n = '0;
				if (dir_n) up_l_n = 1'b1;
				else down_l_n = 1'b1;
			end else begin
				phase_n = PH_POST;
				timer_n = cfg.post_wait_ticks - TIMER_W'(1);
			end
		end
	end

	always_comb begin
		result.step_pulse = pulse_n;
		result.dir_level  = dir_n;
		result.enable_n   = !(phase_n == PH_HIGH || phase_n == PH_LOW);
		result.busy_res   = (phase_n != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			timer_q  <= '0;
			steps_q  <= '0;
			dir_q    <= 1'b0;
			up_l_q   <= 1'b0;
			down_l_q <= 1'b0;
			pulse_q  <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_n;
			timer_q  <= timer_n;
			steps_q  <= steps_n;
			dir_q    <= dir_n;
			up_l_q   <= up_l_n;
			down_l_q <= down_l_n;
			pulse_q  <= pulse_n;
		end
	end

	`include "stepper_button_move_sequencer_assert.svh"

	`SBMS_ASSERT(a_pulse_in_high, clk, arst_n, !pulse_q || phase_q == PH_HIGH, "pulse outside high phase")
	`SBMS_ASSERT(a_one_latch, clk, arst_n, !(up_l_q && down_l_q), "both direction latches set")
	`SBMS_ASSERT(a_steps_live, clk, arst_n, !(phase_q == PH_HIGH || phase_q == PH_LOW) || steps_q != '0, "pulsing with no steps left")
	`SBMS_ASSERT_NEXT(a_idle_holds, clk, arst_n, phase_q == PH_IDLE && !fire, phase_q == PH_IDLE, "left idle without an item")

endmodule

FILE: tb/sv/tb_stepper_button_move_sequencer.sv
// Testbench for the stepper button move sequencer: tick stream with a predictor and APB setup
module tb_stepper_button_move_sequencer;
	timeunit 1ns;
	timeprecision 1ps;

	import sbms_pkg::*;

	localparam logic [1:0] BTN_BOTH = 2'b00;	// {btn_dn_n, btn_up_n}
	localparam logic [1:0] BTN_DN   = 2'b01;
	localparam logic [1:0] BTN_UP   = 2'b10;
	localparam logic [1:0] BTN_NONE = 2'b11;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD   = 48;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;	// btn_up_n, btn_dn_n, zero pad
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;	// step_pulse, dir_level, enable_n, busy_res, zero pad
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	stepper_button_move_sequencer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	cfg_t cfg_shadow = '{HALF_PERIOD_RST, PULSE_COUNT_RST, DIR_SETTLE_RST, POST_WAIT_RST};
	phase_t mv_phase = PH_IDLE;
	logic [TIMER_W-1:0] mv_timer = '0;
	logic [STEP_W-1:0] mv_steps = '0;
	logic mv_dir = 1'b0;
	logic up_done = 1'b0;
	logic down_done = 1'b0;
	logic pulse_lvl = 1'b0;

	logic [1:0] btn_q[$];
	result_t expected_levels[$];
	result_t seen_lv, want_lv;
	string level_names[4] = '{"step_pulse", "dir_level", "enable_n", "busy_res"};

	int errors = 0;
	int ticks_sent = 0;
	int levels_checked = 0;
	int settings_used = 0;
	int up_moves = 0;
	int down_moves = 0;
	int src_gap_max = 0;
	int rx_gap_max = 0;
	int src_gap = 0;
	int rx_wait = 0;
	int rx_draw;
	int quiet_cycles = 0;

	function automatic logic [HALF_W-1:0] pulse_half();
		return (cfg_shadow.half_period_ticks == '0) ? HALF_W'(1) : cfg_shadow.half_period_ticks;
	endfunction

	function automatic void set_latch();
		if (mv_dir)
			up_done = 1'b1;
		else
			down_done = 1'b1;
	endfunction

	function automatic void finish_move();
		pulse_lvl = 1'b0;
		if (cfg_shadow.post_wait_ticks == '0) begin
			mv_phase = PH_IDLE;
			mv_timer = '0;
			set_latch();
		end else begin
			mv_phase = PH_POST;
			mv_timer = cfg_shadow.post_wait_ticks - 1'b1;
		end
	endfunction

	function automatic void raise_pulse();
		mv_phase = PH_HIGH;
		pulse_lvl = 1'b1;
		mv_timer = TIMER_W'(pulse_half() - 1'b1);
	endfunction

	function automatic void start_pulses();
		mv_steps = cfg_shadow.pulse_count;
		if (mv_steps == '0)
			finish_move();
		else
			raise_pulse();
	endfunction

	function automatic void launch_move(input logic up);
		mv_dir = up;
		if (up) begin
			down_done = 1'b0;
			up_moves++;
		end else begin
			up_done = 1'b0;
			down_moves++;
		end
		pulse_lvl = 1'b0;
		if (cfg_shadow.dir_settle_ticks == '0) begin
			start_pulses();
		end else begin
			mv_phase = PH_SETTLE;
			mv_timer = cfg_shadow.dir_settle_ticks - 1'b1;
		end
	endfunction

	// one timer tick; returns the line levels after it
	function automatic result_t advance_sequencer(input logic up_n, input logic down_n);
		result_t lv;
		case (mv_phase)
			PH_SETTLE: begin
				if (mv_timer != '0)
					mv_timer--;
				else
					start_pulses();
			end
			PH_HIGH: begin
				if (mv_timer != '0) begin
					mv_timer--;
				end else begin
					mv_phase = PH_LOW;
					pulse_lvl = 1'b0;
					mv_timer = TIMER_W'(pulse_half() - 1'b1);
				end
			end
			PH_LOW: begin
				if (mv_timer != '0) begin
					mv_timer--;
				end else begin
					mv_steps--;
					if (mv_steps == '0)
						finish_move();
					else
						raise_pulse();
				end
			end
			PH_POST: begin
				if (mv_timer != '0) begin
					mv_timer--;
				end else begin
					mv_phase = PH_IDLE;
					set_latch();
				end
			end
			default: begin
				mv_phase = PH_IDLE;
				if (!up_n && !up_done)
					launch_move(1'b1);
				else if (!down_n && !down_done)
					launch_move(1'b0);
			end
		endcase
		lv.step_pulse = pulse_lvl;
		lv.dir_level = mv_dir;
		lv.enable_n = !(mv_phase == PH_HIGH || mv_phase == PH_LOW);
		lv.busy_res = (mv_phase != PH_IDLE);
		return lv;
	endfunction

	// tick driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			src_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_levels.push_back(advance_sequencer(s_axis_tdata[0], s_axis_tdata[1]));
				ticks_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap != 0) begin
					src_gap <= src_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (btn_q.size() != 0) begin
					s_axis_tdata <= {6'd0, btn_q.pop_front()};
					s_axis_tvalid <= 1'b1;
					src_gap <= $urandom_range(0, src_gap_max);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// level monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen_lv = result_t'(m_axis_tdata[3:0]);
				if (expected_levels.size() == 0) begin
					if (errors < 50)
						$display("%0t: item %b arrived with none expected", $time, seen_lv);
					errors++;
				end else begin
					want_lv = expected_levels.pop_front();
					for (int f = 0; f < 4; f++) begin
						if (seen_lv[f] !== want_lv[f]) begin
							if (errors < 50)
								$display("%0t: %s expected %b got %b", $time, level_names[f],
									want_lv[f], seen_lv[f]);
							errors++;
						end
					end
				end
				levels_checked++;
				rx_draw = (levels_checked % 400 == 200) ? LONG_HOLD :
					$urandom_range(0, rx_gap_max);
				rx_wait <= rx_draw;
				m_axis_tready <= (rx_draw == 0);
			end else if (rx_wait > 1) begin
				rx_wait <= rx_wait - 1;
				m_axis_tready <= 1'b0;
			end else begin
				rx_wait <= 0;
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || psel || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_HALF_PERIOD: cfg_shadow.half_period_ticks = val[HALF_W-1:0];
			REG_PULSE_COUNT: cfg_shadow.pulse_count = val[STEP_W-1:0];
			REG_DIR_SETTLE: cfg_shadow.dir_settle_ticks = val[TIMER_W-1:0];
			REG_POST_WAIT: cfg_shadow.post_wait_ticks = val[TIMER_W-1:0];
			default: ;
		endcase
	endtask

	task automatic verify_reg(input logic [1:0] idx);
		logic [31:0] want;
		case (idx)
			REG_HALF_PERIOD: want = 32'(cfg_shadow.half_period_ticks);
			REG_PULSE_COUNT: want = 32'(cfg_shadow.pulse_count);
			REG_DIR_SETTLE: want = 32'(cfg_shadow.dir_settle_ticks);
			default: want = 32'(cfg_shadow.post_wait_ticks);
		endcase
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$display("%0t: register %0d expected %h got %h", $time, idx, want, prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_timing(input logic [31:0] half, input logic [31:0] steps,
			input logic [31:0] settle, input logic [31:0] post);
		write_reg(REG_HALF_PERIOD, half);
		write_reg(REG_PULSE_COUNT, steps);
		write_reg(REG_DIR_SETTLE, settle);
		write_reg(REG_POST_WAIT, post);
		for (int r = 0; r < 4; r++)
			verify_reg(2'(r));
		settings_used++;
		@(negedge clk);
	endtask

	task automatic hold_buttons(input logic [1:0] btn, input int unsigned n);
		repeat (n) btn_q.push_back(btn);
	endtask

	task automatic await_drain();
		while (btn_q.size() != 0 || s_axis_tvalid || expected_levels.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned ph, n, k, pick;
		logic [1:0] btn;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		for (int r = 0; r < 4; r++)
			verify_reg(2'(r));

		// unit lengths: both pressed, presses during a move, latch blocking
		src_gap_max = 6;
		rx_gap_max = 6;
		program_timing(32'd1, 32'd1, 32'd1, 32'd1);
		hold_buttons(BTN_NONE, 1);
		hold_buttons(BTN_BOTH, 1);
		hold_buttons(BTN_DN, 3);
		hold_buttons(BTN_NONE, 2);
		hold_buttons(BTN_UP, 1);
		hold_buttons(BTN_DN, 1);
		hold_buttons(BTN_UP, 4);
		hold_buttons(BTN_DN, 1);
		hold_buttons(BTN_BOTH, 1);
		hold_buttons(BTN_NONE, 5);
		await_drain();

		// all zero: moves finish in the tick that starts them
		program_timing(32'd0, 32'd0, 32'd0, 32'd0);
		hold_buttons(BTN_UP, 2);
		hold_buttons(BTN_DN, 1);
		hold_buttons(BTN_BOTH, 2);
		await_drain();

		// zero half period acts as one tick
		program_timing(32'd0, 32'd2, 32'd0, 32'd0);
		hold_buttons(BTN_BOTH, 1);
		hold_buttons(BTN_NONE, 6);
		await_drain();

		for (ph = 0; ph < 8; ph++) begin
			src_gap_max = (ph % 3 == 2) ? 0 : 6;
			rx_gap_max = (ph % 4 == 3) ? 0 : 6;
			program_timing($urandom_range(0, 4), $urandom_range(0, 6), $urandom_range(0, 8),
				$urandom_range(0, 8));
			n = 0;
			while (n < 140) begin
				pick = $urandom_range(0, 9);
				btn = (pick < 4) ? BTN_NONE : (pick < 6) ? BTN_UP : (pick < 8) ? BTN_DN :
					(pick == 8) ? BTN_BOTH : 2'($urandom);
				k = $urandom_range(1, 8);
				hold_buttons(btn, k);
				n += k;
			end
			// longer than any move at these settings, so the block ends idle
			hold_buttons(BTN_NONE, 80);
			await_drain();
		end

		// upper register bits dropped on write, back to back ticks
		src_gap_max = 0;
		rx_gap_max = 0;
		program_timing(32'hFFFF_0002, 32'hFFFF_0003, 32'hFFF0_0001, 32'hFFF0_0002);
		hold_buttons(BTN_BOTH, 1);
		repeat (30) btn_q.push_back(2'($urandom));
		hold_buttons(BTN_NONE, 20);
		await_drain();

		// longest settle and post times, idle ticks only
		program_timing(32'd1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		hold_buttons(BTN_NONE, 20);
		await_drain();

		repeat (10) @(posedge clk);
		if (expected_levels.size() != 0) begin
			$display("%0t: %0d expected items never arrived", $time, expected_levels.size());
			errors++;
		end
		$display("Checked %0d ticks over %0d timing settings, %0d up and %0d down moves,",
			ticks_sent, settings_used, up_moves, down_moves);
		$display("including zero lengths, truncated register writes and full-width waits.");
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/sbms_pkg.sv
rtl/sbms_regs.sv
rtl/sbms_core.sv
rtl/stepper_button_move_sequencer.sv
tb/sv/tb_stepper_button_move_sequencer.sv
